/* rtl/point_in_polygon_test_macros.svh */
// Assertion macros shared by the polygon test RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

`ifndef ASSERT_OFF
// plain property, sampled on the clock, off during reset
`define PIP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent in one cycle, consequent in the next
`define PIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PIP_ASSERT(lbl, clk, rst_n, prop, msg)
`define PIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/pip_pkg.sv */
`timescale 1ns / 1ps
// Constants, codes and state type for the point-in-polygon block.
// No dependencies; used by the interfaces and the point_in_polygon_test module.
package pip_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int COORD_W      = 16;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int VTX_W        = 2 * COORD_W;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREV,
        S_DIFF,
        S_MUL_L,
        S_MUL_R,
        S_CMP,
        S_OUT
    } t_state;

endpackage

/* rtl/pip_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the point-in-polygon block.
// Depends on pip_pkg for field widths.
interface pip_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          mode;
    logic signed [pip_pkg::COORD_W-1:0]  coord_x;
    logic signed [pip_pkg::COORD_W-1:0]  coord_y;

    modport source (output valid, mode, coord_x, coord_y, input ready);
    modport sink   (input valid, mode, coord_x, coord_y, output ready);
endinterface

interface pip_out_if;
    logic                        valid;
    logic                        ready;
    logic                        inside_res;
    logic [pip_pkg::CNT_W-1:0]   vertex_count;
    logic                        status;

    modport source (output valid, inside_res, vertex_count, status, input ready);
    modport sink   (input valid, inside_res, vertex_count, status, output ready);
endinterface

/* rtl/pip_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/point_in_polygon_test.sv */
`timescale 1ns / 1ps
// Even-odd point-in-polygon test over a vertex table of up to 16 entries.
// Clear / append: the result word is registered at the edge that accepts the word.
// Query over n vertices: the last vertex is read first, then per edge one vertex RAM
// read, diff / two passes of the shared 17x17 multiplier / compare; result when output free.
// Reset (synchronous, active low) empties the table and clears the output valid flag.
`include "point_in_polygon_test_macros.svh"

module point_in_polygon_test (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pip_in_if.sink     i_in,
    pip_out_if.source  o_out
);

    localparam int COORD_W = pip_pkg::COORD_W;
    localparam int IDX_W   = pip_pkg::IDX_W;
    localparam int CNT_W   = pip_pkg::CNT_W;
    localparam int DIFF_W  = pip_pkg::DIFF_W;
    localparam int PROD_W  = pip_pkg::PROD_W;
    localparam int VTX_W   = pip_pkg::VTX_W;

    pip_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_cur, n_cur;
    logic             r_parity, n_parity;
    logic             r_out_valid, n_out_valid;
    logic             r_out_inside, n_out_inside;
    logic [CNT_W-1:0] r_out_count, n_out_count;
    logic             r_out_status, n_out_status;

    logic signed [COORD_W-1:0] r_px, n_px, r_py, n_py;
    logic signed [COORD_W-1:0] r_ex, n_ex, r_ey, n_ey;
    logic signed [COORD_W-1:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [DIFF_W-1:0]  r_dpx, n_dpx, r_dy, n_dy;
    logic signed [DIFF_W-1:0]  r_dpy, n_dpy, r_dex, n_dex;
    logic                      r_strad, n_strad, r_dy_pos, n_dy_pos;
    logic signed [PROD_W-1:0]  r_lhs, n_lhs, r_rhs, n_rhs;

    logic                      in_fire;
    logic                      out_free;
    logic                      full;
    logic [IDX_W-1:0]          last_idx;
    logic                      ram_we;
    logic [IDX_W-1:0]          ram_raddr;
    logic [VTX_W-1:0]          ram_rdata;
    logic signed [COORD_W-1:0] rd_x, rd_y;
    logic signed [DIFF_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic                      left;

    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == pip_pkg::S_IDLE) && out_free;
    assign in_fire     = i_in.valid && i_in.ready;
    assign full        = r_count == CNT_W'(pip_pkg::MAX_VERTICES);
    assign last_idx    = IDX_W'(r_count - CNT_W'(1));

    pip_ram #(.WIDTH(VTX_W), .DEPTH(pip_pkg::MAX_VERTICES)) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({i_in.coord_y, i_in.coord_x}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_x = $signed(ram_rdata[COORD_W-1:0]);
    assign rd_y = $signed(ram_rdata[VTX_W-1:COORD_W]);

    // shared multiplier: (px-sx)*dy first, then (py-sy)*(ex-sx)
    assign mul_a = (r_state == pip_pkg::S_MUL_R) ? r_dpy : r_dpx;
    assign mul_b = (r_state == pip_pkg::S_MUL_R) ? r_dex : r_dy;
    assign mul_p = mul_a * mul_b;

    // inequality flips with the sign of the edge's y step
    assign left = r_dy_pos ? (r_lhs < r_rhs) : (r_lhs > r_rhs);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_cur        = r_cur;
        n_parity     = r_parity;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_inside = r_out_inside;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        n_px         = r_px;
        n_py         = r_py;
        n_ex         = r_ex;
        n_ey         = r_ey;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_dpx        = r_dpx;
        n_dy         = r_dy;
        n_dpy        = r_dpy;
        n_dex        = r_dex;
        n_strad      = r_strad;
        n_dy_pos     = r_dy_pos;
        n_lhs        = r_lhs;
        n_rhs        = r_rhs;
        ram_we       = 1'b0;
        ram_raddr    = r_cur;

        case (r_state)
            pip_pkg::S_IDLE: begin
                ram_raddr = last_idx;
                if (in_fire) begin
                    n_out_inside = 1'b0;
                    n_out_status = 1'b0;
                    n_out_count  = r_count;
                    n_out_valid  = 1'b1;
                    case (i_in.mode)
                        pip_pkg::MODE_CLEAR: begin
                            n_count     = '0;
                            n_out_count = '0;
                        end
                        pip_pkg::MODE_APPEND: begin
                            if (full) begin
                                n_out_status = 1'b1;
                            end else begin
                                ram_we      = 1'b1;
                                n_count     = r_count + CNT_W'(1);
                                n_out_count = r_count + CNT_W'(1);
                            end
                        end
                        pip_pkg::MODE_QUERY: begin
                            n_px     = i_in.coord_x;
                            n_py     = i_in.coord_y;
                            n_cur    = '0;
                            n_parity = 1'b0;
                            // empty table answers at once
                            if (r_count != '0) begin
                                n_out_valid = 1'b0;
                                n_state     = pip_pkg::S_PREV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pip_pkg::S_PREV: begin
                // last vertex opens the walk as the edge's far end
                n_ex    = rd_x;
                n_ey    = rd_y;
                n_state = pip_pkg::S_DIFF;
            end
            pip_pkg::S_DIFF: begin
                n_cx     = rd_x;
                n_cy     = rd_y;
                n_dpx    = DIFF_W'(r_px) - DIFF_W'(rd_x);
                n_dy     = DIFF_W'(r_ey) - DIFF_W'(rd_y);
                n_dpy    = DIFF_W'(r_py) - DIFF_W'(rd_y);
                n_dex    = DIFF_W'(r_ex) - DIFF_W'(rd_x);
                n_dy_pos = r_ey > rd_y;
                n_strad  = (r_ey < r_py && rd_y >= r_py) || (rd_y < r_py && r_ey >= r_py);
                n_state  = pip_pkg::S_MUL_L;
            end
            pip_pkg::S_MUL_L: begin
                n_lhs   = mul_p;
                n_state = pip_pkg::S_MUL_R;
            end
            pip_pkg::S_MUL_R: begin
                n_rhs   = mul_p;
                n_state = pip_pkg::S_CMP;
            end
            pip_pkg::S_CMP: begin
                if (r_strad && left) begin
                    n_parity = !r_parity;
                end
                n_ex = r_cx;
                n_ey = r_cy;
                if (r_cur == last_idx) begin
                    n_state = pip_pkg::S_OUT;
                end else begin
                    n_cur     = r_cur + IDX_W'(1);
                    ram_raddr = r_cur + IDX_W'(1);
                    n_state   = pip_pkg::S_DIFF;
                end
            end
            pip_pkg::S_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_inside = r_parity;
                    n_out_count  = r_count;
                    n_out_status = 1'b0;
                    n_state      = pip_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pip_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pip_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_parity     <= n_parity;
        r_out_inside <= n_out_inside;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
        r_px         <= n_px;
        r_py         <= n_py;
        r_ex         <= n_ex;
        r_ey         <= n_ey;
        r_cx         <= n_cx;
        r_cy         <= n_cy;
        r_dpx        <= n_dpx;
        r_dy         <= n_dy;
        r_dpy        <= n_dpy;
        r_dex        <= n_dex;
        r_strad      <= n_strad;
        r_dy_pos     <= n_dy_pos;
        r_lhs        <= n_lhs;
        r_rhs        <= n_rhs;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.inside_res   = r_out_inside;
    assign o_out.vertex_count = r_out_count;
    assign o_out.status       = r_out_status;

    `PIP_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(pip_pkg::MAX_VERTICES), "vertex count beyond table depth")
    `PIP_ASSERT(a_walk_in_table, i_clk, i_rst_n, r_state == pip_pkg::S_IDLE || r_state == pip_pkg::S_OUT || {1'b0, r_cur} < r_count, "edge walk index past vertex count")
    `PIP_ASSERT(a_count_on_item, i_clk, i_rst_n, $stable(r_count) || $past(in_fire), "vertex count changed without an accepted word")
    `PIP_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, in_fire && i_in.mode == pip_pkg::MODE_QUERY && r_count != '0, r_state == pip_pkg::S_PREV, "query over a non-empty table did not start a walk")

endmodule
